// ===== rtl/phe_pkg.sv =====
// Shared widths, command codes and field layout for the polynomial evaluator.
package phe_pkg;

    // Field widths fixed by the item format
    localparam int DATA_W    = 32;
    localparam int IDX_W     = 4;
    localparam int TERM_W    = 5;
    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 32;

    // Bit positions inside the slave tdata word
    localparam int IDX_LSB  = 0;
    localparam int COEF_LSB = IDX_LSB + IDX_W;
    localparam int X_LSB    = COEF_LSB + DATA_W;

    // Command codes carried on the slave tuser
    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } t_cmd;

endpackage

// ===== rtl/phe_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module phe_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/polynomial_horner_evaluator.sv =====
// Polynomial evaluator by Horner's rule over a stored coefficient table.
//
// A slave transfer with tuser = write loads one Q16.16 coefficient (index 0 is
// the highest order term) and completes in its accept cycle; indexes from
// MAX_TERMS up are dropped. A transfer with tuser = evaluate runs Horner's rule
// over the first term_count coefficients (zero counts as one, counts above
// MAX_TERMS are clamped) at x and returns the value on the master side, with
// tuser set if any multiply-add step clipped to 32 bits. Each step rounds the
// exact product to FRAC_BITS fraction bits (half up), adds the coefficient and
// saturates. One 32x32 multiplier and one add/clamp stage are shared by all
// steps; each step passes a multiply state and an add state, and the next
// transfer is taken only once the evaluation is finished. The result waits
// in an output register, and a result not yet taken only stalls the next
// evaluation in its done state. The coefficient table sits in one RAM with
// per-entry valid flags cleared by reset, so there is no clearing pass:
// unwritten entries read as zero right after reset.
module polynomial_horner_evaluator
    import phe_pkg::*;
#(
    parameter int MAX_TERMS = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write: term_count
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [TERM_W-1:0]    i_cfg_data,
    // Slave stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    // [3:0] coef_index, [35:4] coef_value, [67:36] x_value, [71:68] zero
    input  logic [S_TDATA_W-1:0] i_s_tdata,
    // [0] cmd
    input  logic                 i_s_tuser,
    // Master stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [31:0] poly_value
    output logic [M_TDATA_W-1:0] o_m_tdata,
    // [0] saturated
    output logic                 o_m_tuser
);

    localparam int AW     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int RB     = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
    localparam int SUM_W  = 2 * DATA_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIRST,
        S_MUL,
        S_ADD,
        S_DONE
    } t_state;

    t_state                    r_state;
    logic [TERM_W-1:0]         r_term_count;
    logic [MAX_TERMS-1:0]      r_valid;
    logic                      r_rd_vld;
    logic [AW-1:0]             r_idx;
    logic [AW-1:0]             r_last;
    logic signed [DATA_W-1:0]  r_x;
    logic signed [DATA_W-1:0]  r_acc;
    logic signed [DATA_W-1:0]  r_coef;
    logic signed [2*DATA_W-1:0] r_prod;
    logic                      r_sat;
    logic                      r_out_valid;
    logic [DATA_W-1:0]         r_out_data;
    logic                      r_out_sat;

    logic                      w_s_xfer;
    logic                      w_is_eval;
    logic [IDX_W-1:0]          w_in_idx;
    logic [DATA_W-1:0]         w_in_coef;
    logic [DATA_W-1:0]         w_in_x;
    logic                      w_wr_ok;
    logic                      w_we;
    logic [AW-1:0]             w_waddr;
    logic [AW-1:0]             w_raddr;
    logic [DATA_W-1:0]         w_rdata;
    logic signed [DATA_W-1:0]  w_coef_rd;
    logic [31:0]               w_n;
    logic [AW-1:0]             w_last;
    logic signed [2*DATA_W-1:0] w_prod;
    logic signed [2*DATA_W-1:0] w_shift;
    logic                      w_rbit;
    logic signed [SUM_W-1:0]   w_sum;
    logic                      w_ovf;
    logic signed [DATA_W-1:0]  w_step;
    logic                      w_out_load;

    // Unpack the slave transfer
    assign w_in_idx  = i_s_tdata[IDX_LSB +: IDX_W];
    assign w_in_coef = i_s_tdata[COEF_LSB +: DATA_W];
    assign w_in_x    = i_s_tdata[X_LSB +: DATA_W];
    assign w_is_eval = (t_cmd'(i_s_tuser) == CMD_EVAL);

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_s_xfer    = i_s_tvalid && o_s_tready;

    // Coefficient write decode; out-of-range indexes are dropped
    assign w_wr_ok = (32'(w_in_idx) < 32'(MAX_TERMS));
    assign w_we    = w_s_xfer && !w_is_eval && w_wr_ok;
    assign w_waddr = AW'(w_in_idx);

    // Effective term count: zero acts as one, clamp to the table depth
    always_comb begin
        w_n = (r_term_count == '0) ? 32'd1 : 32'(r_term_count);
        if (w_n > 32'(MAX_TERMS)) begin
            w_n = 32'(MAX_TERMS);
        end
    end
    assign w_last = AW'(w_n - 32'd1);

    // Read address: the entry whose data is needed in the following cycle
    always_comb begin
        unique case (r_state)
            S_IDLE:  w_raddr = '0;
            S_FIRST: w_raddr = r_idx + AW'(1);
            S_ADD:   w_raddr = r_idx + AW'(1);
            S_MUL:   w_raddr = r_idx;
            S_DONE:  w_raddr = r_idx;
            default: w_raddr = r_idx;
        endcase
    end

    phe_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_TERMS)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_in_coef),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // Never-written entries read as zero
    assign w_coef_rd = r_rd_vld ? $signed(w_rdata) : '0;

    // Shared multiplier
    assign w_prod = r_acc * r_x;

    // Round half up to FRAC_BITS, add coefficient, detect overflow of 32 bits
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_rbit  = (FRAC_BITS > 0) && r_prod[RB];
    assign w_sum   = {{2{w_shift[2*DATA_W-1]}}, w_shift}
                   + {{(SUM_W-DATA_W){r_coef[DATA_W-1]}}, r_coef}
                   + SUM_W'(w_rbit);
    assign w_ovf   = (w_sum[SUM_W-1:DATA_W-1] != '0) && (w_sum[SUM_W-1:DATA_W-1] != '1);

    always_comb begin
        if (!w_ovf) begin
            w_step = w_sum[DATA_W-1:0];
        end else if (w_sum[SUM_W-1]) begin
            w_step = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            w_step = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    // Sequencer, coefficient flags and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_term_count <= TERM_W'(1);
            r_valid      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // Configuration transfer
            if (i_cfg_valid) begin
                r_term_count <= i_cfg_data;
            end

            // Mark written entries
            if (w_we) begin
                r_valid[w_waddr] <= 1'b1;
            end
            r_rd_vld <= r_valid[w_raddr];

            // Drop a taken result, then load a new one
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_out_data  <= r_acc;
                r_out_sat   <= r_sat;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_s_xfer && w_is_eval) begin
                        r_x     <= $signed(w_in_x);
                        r_last  <= w_last;
                        r_idx   <= '0;
                        r_state <= S_FIRST;
                    end
                end
                S_FIRST: begin
                    r_acc <= w_coef_rd;
                    r_sat <= 1'b0;
                    if (r_last == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_coef  <= w_coef_rd;
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_acc <= w_step;
                    r_sat <= r_sat | w_ovf;
                    if (r_idx == r_last) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + AW'(1);
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_sat;

`ifndef SYNTH
    // A new result only appears when an evaluation finishes
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside the done step");

    // The term counter never passes the last term while stepping
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL || r_state == S_ADD) |-> (r_idx <= r_last))
        else $error("term index past last term");

    // A single-term evaluation never reports saturation
    a_single_no_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_m_tvalid) && r_last == '0) |-> !o_m_tuser)
        else $error("saturation flagged on a single term");

    // The slave side closes once an evaluation is accepted
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_xfer && w_is_eval) |=> !o_s_tready)
        else $error("slave ready during evaluation");
`endif

endmodule

// ===== tb/polynomial_horner_evaluator_tb.sv =====
// Self-checking testbench for the Horner polynomial evaluator stream block.
`timescale 1ns / 100ps

module polynomial_horner_evaluator_tb
    import phe_pkg::*;
();

    localparam int MAX_TERMS        = 16;
    localparam int FRAC_BITS        = 16;
    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 12;
    localparam int SETTLE_CYCLES    = 40;
    localparam int STALL_LIMIT      = 5000;
    localparam int HOLDOFF_CYCLES   = 400;
    localparam int HOLDOFF_ITEMS    = 40;
    localparam int ITEMS_PER_PHASE  = 495;
    localparam int COUNTS_PER_PHASE = 5;
    localparam int EVAL_PCT         = 40;
    localparam int COEF_SPAN        = 32'h0004_0000;  // +/- 4.0
    localparam int X_SPAN           = 32'h0001_8000;  // +/- 1.5

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     sat;
    } t_poly_result;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [TERM_W-1:0]    i_cfg_data  = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata   = '0;
    logic                 i_s_tuser   = 1'b0;
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tuser;

    // Shadow copy of the block's table and term count
    logic signed [DATA_W-1:0] coef_table [MAX_TERMS];
    logic [TERM_W-1:0]        term_count_reg = 5'd1;
    t_poly_result             pending_results [$];

    logic [DATA_W-1:0] edge_values [6] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                           32'h0000_0001, 32'hFFFF_FFFF, 32'h0001_0000};

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int rx_hold_cycles = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;

    polynomial_horner_evaluator #(
        .MAX_TERMS(MAX_TERMS),
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Evaluate the shadow polynomial at x: round half up, add, clamp per step
    function automatic t_poly_result horner_predict(input logic signed [DATA_W-1:0] x);
        int                 n;
        int                 step;
        logic signed [63:0] acc;
        logic signed [63:0] prod;
        logic signed [63:0] sum;
        t_poly_result       r;
        n = term_count_reg;
        if (n == 0) n = 1;
        if (n > MAX_TERMS) n = MAX_TERMS;
        r.sat = 1'b0;
        acc   = coef_table[0];
        for (step = 1; step < n; step++) begin
            prod = acc * x;
            prod = prod + (64'sd1 <<< (FRAC_BITS - 1));
            sum  = (prod >>> FRAC_BITS) + coef_table[step];
            if (sum > Q_MAX) begin
                sum   = Q_MAX;
                r.sat = 1'b1;
            end else if (sum < Q_MIN) begin
                sum   = Q_MIN;
                r.sat = 1'b1;
            end
            acc = sum;
        end
        r.value = acc[DATA_W-1:0];
        return r;
    endfunction

    // Mix of full-range, corner and small-magnitude fixed-point values
    function automatic logic [DATA_W-1:0] random_q16(input int span);
        case ($urandom_range(0, 9))
            0, 1, 2: random_q16 = $urandom;
            3:       random_q16 = edge_values[$urandom_range(0, 5)];
            default: random_q16 = DATA_W'($urandom_range(0, 2 * span)) - DATA_W'(span);
        endcase
    endfunction

    // Offer one item, wait for its transfer, then update the shadow state
    task automatic send_item(input t_cmd cmd, input logic [IDX_W-1:0] idx,
                             input logic [DATA_W-1:0] coef, input logic [DATA_W-1:0] x);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {{(S_TDATA_W - X_LSB - DATA_W){1'b0}}, x, coef, idx};
        do @(posedge i_clk); while (!o_s_tready);
        if (cmd == CMD_WRITE) begin
            if (int'(idx) < MAX_TERMS) coef_table[idx] = coef;
        end else begin
            pending_results.push_back(horner_predict(x));
        end
    endtask

    task automatic send_random_item();
        t_cmd cmd;
        cmd = ($urandom_range(0, 99) < EVAL_PCT) ? CMD_EVAL : CMD_WRITE;
        send_item(cmd, IDX_W'($urandom_range(0, MAX_TERMS - 1)),
                  random_q16(COEF_SPAN), random_q16(X_SPAN));
    endtask

    // Drop valid, let every pending result arrive, then let the block settle
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_term_count(input logic [TERM_W-1:0] count);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= count;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid    <= 1'b0;
        term_count_reg  = count;
    endtask

    // Store must read as zero after reset, at default and full term count
    task automatic test_cleared_store();
        send_item(CMD_EVAL, '0, '0, 32'h7FFF_FFFF);
        write_term_count(5'd16);
        send_item(CMD_EVAL, '0, '0, 32'h0001_0000);
        send_item(CMD_EVAL, '0, '0, 32'h8000_0000);
    endtask

    // One term: value is the leading coefficient, never flagged
    task automatic test_single_term();
        write_term_count(5'd1);
        send_item(CMD_WRITE, 4'd0, 32'h8000_0000, '0);
        send_item(CMD_EVAL, '0, '0, 32'h7FFF_FFFF);
        send_item(CMD_WRITE, 4'd0, 32'h7FFF_FFFF, '0);
        send_item(CMD_EVAL, '0, '0, 32'h8000_0000);
    endtask

    // Half-LSB ties on both signs, then clipping in both directions
    task automatic test_rounding_and_clipping();
        write_term_count(5'd2);
        send_item(CMD_WRITE, 4'd1, 32'h0000_0000, '0);
        send_item(CMD_WRITE, 4'd0, 32'h0000_0001, '0);
        send_item(CMD_EVAL, '0, '0, 32'h0000_8000);
        send_item(CMD_WRITE, 4'd0, 32'hFFFF_FFFF, '0);
        send_item(CMD_EVAL, '0, '0, 32'h0000_8000);
        send_item(CMD_WRITE, 4'd0, 32'h8000_0000, '0);
        send_item(CMD_EVAL, '0, '0, 32'h7FFF_FFFF);
        send_item(CMD_EVAL, '0, '0, 32'h8000_0000);
    endtask

    // All sixteen terms with extreme values at both ends of the table
    task automatic test_full_table();
        write_term_count(5'd16);
        send_item(CMD_WRITE, 4'd0, 32'h0001_0000, '0);
        send_item(CMD_WRITE, 4'd15, 32'h7FFF_FFFF, '0);
        send_item(CMD_EVAL, '0, '0, 32'h0000_0000);
        send_item(CMD_EVAL, '0, '0, 32'h7FFF_FFFF);
        send_item(CMD_EVAL, '0, '0, 32'h8000_0000);
    endtask

    // Zero counts as one term; counts above the table size are clamped
    task automatic test_term_count_limits();
        write_term_count(5'd0);
        send_item(CMD_EVAL, '0, '0, 32'h0002_0000);
        write_term_count(5'd31);
        send_item(CMD_EVAL, '0, '0, 32'hFFFF_0000);
        write_term_count(5'd17);
        send_item(CMD_EVAL, '0, '0, 32'h0000_C000);
    endtask

    // Random writes and evaluations across several term counts
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int items);
        int setting;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (setting = 0; setting < COUNTS_PER_PHASE; setting++) begin
            case (setting)
                0:       write_term_count(5'd16);
                1:       write_term_count(TERM_W'($urandom_range(2, 8)));
                2:       write_term_count(5'd1);
                3:       write_term_count(TERM_W'($urandom_range(0, 31)));
                default: write_term_count(TERM_W'($urandom_range(9, 15)));
            endcase
            repeat (items / COUNTS_PER_PHASE) send_random_item();
        end
    endtask

    // Hold the output off while evaluations keep coming, so the input stalls
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        write_term_count(5'd3);
        rx_hold_cycles <= HOLDOFF_CYCLES;
        repeat (HOLDOFF_ITEMS) send_item(CMD_EVAL, '0, '0, random_q16(X_SPAN));
        wait_for_results();
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_cycles > 0) begin
            i_m_tready     <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_poly_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: poly_value %h saturated %b", o_m_tdata, o_m_tuser);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.value) begin
                    $error("poly_value: expected %h, actual %h", want.value, o_m_tdata);
                    fail_count++;
                end
                if (o_m_tuser !== want.sat) begin
                    $error("saturated: expected %b, actual %b", want.sat, o_m_tuser);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("polynomial_horner_evaluator_tb: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        foreach (coef_table[k]) coef_table[k] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct  = 36;
        recv_stall_pct = 83;
        test_cleared_store();
        test_single_term();
        test_rounding_and_clipping();
        test_full_table();
        test_term_count_limits();

        test_random_traffic(36, 83, ITEMS_PER_PHASE);
        test_random_traffic(83, 36, ITEMS_PER_PHASE);
        test_output_holdoff();
        test_random_traffic(0, 0, ITEMS_PER_PHASE);

        wait_for_results();
        if (fail_count == 0) begin
            $display("polynomial_horner_evaluator_tb: clean");
        end else begin
            $display("polynomial_horner_evaluator_tb: errors");
        end
        $finish;
    end

endmodule
